/* src/bclru_pkg.sv */
// shared types and constants for the buffer cache directory
// no dependencies
`default_nettype none

package bclru_pkg;

    localparam int NBUF = 32;
    localparam int IDXW = (NBUF > 1) ? $clog2(NBUF) : 1;
    localparam int GRP  = 8;
    localparam int NGRP = (NBUF + GRP - 1) / GRP;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef logic [IDXW-1:0] t_slot;
    typedef logic [IDXW-1:0] t_rank;

    typedef enum logic [1:0] {
        ACT_ACQUIRE = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_PIN     = 2'd2,
        ACT_UNPIN   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_UNDER  = 2'd2,
        ST_OVER   = 2'd3
    } t_status;

    typedef struct packed {
        t_action     action;
        logic [7:0]  device;
        logic [31:0] sector;
        logic [4:0]  slot_in;
    } t_req;

    typedef struct packed {
        logic [4:0] slot_out;
        logic       hit;
        logic       needs_read;
        logic [7:0] count_after;
        t_status    status;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic commit;
    } t_cmd;

endpackage

`default_nettype wire

/* src/bclru_sel.sv */
// two-stage registered select tree: lowest key among the masked lanes
// depends on bclru_pkg
`default_nettype none

module bclru_sel (
    input  wire logic                 i_clk,
    input  wire logic [bclru_pkg::NBUF-1:0] i_mask,
    input  wire bclru_pkg::t_rank     i_key [bclru_pkg::NBUF],
    output logic                      o_found,
    output bclru_pkg::t_slot          o_idx
);

    logic             r_gfound [bclru_pkg::NGRP];
    bclru_pkg::t_slot r_gidx   [bclru_pkg::NGRP];
    bclru_pkg::t_rank r_gkey   [bclru_pkg::NGRP];

    logic             n_gfound [bclru_pkg::NGRP];
    bclru_pkg::t_slot n_gidx   [bclru_pkg::NGRP];
    bclru_pkg::t_rank n_gkey   [bclru_pkg::NGRP];

    logic             n_found;
    bclru_pkg::t_slot n_idx;
    bclru_pkg::t_rank n_key;

    // first level: one winner per group of lanes
    always_comb begin
        int li;
        for (int g = 0; g < bclru_pkg::NGRP; g++) begin
            n_gfound[g] = 1'b0;
            n_gidx[g]   = '0;
            n_gkey[g]   = '0;
            for (int k = 0; k < bclru_pkg::GRP; k++) begin
                li = g * bclru_pkg::GRP + k;
                if (li < bclru_pkg::NBUF) begin
                    if (i_mask[li] && (!n_gfound[g] || i_key[li] < n_gkey[g])) begin
                        n_gfound[g] = 1'b1;
                        n_gidx[g]   = bclru_pkg::IDXW'(li);
                        n_gkey[g]   = i_key[li];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < bclru_pkg::NGRP; g++) begin
            r_gfound[g] <= n_gfound[g];
            r_gidx[g]   <= n_gidx[g];
            r_gkey[g]   <= n_gkey[g];
        end
    end

    // second level across the groups
    always_comb begin
        n_found = 1'b0;
        n_idx   = '0;
        n_key   = '0;
        for (int g = 0; g < bclru_pkg::NGRP; g++) begin
            if (r_gfound[g] && (!n_found || r_gkey[g] < n_key)) begin
                n_found = 1'b1;
                n_idx   = r_gidx[g];
                n_key   = r_gkey[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_found <= n_found;
        o_idx   <= n_idx;
    end

endmodule

`default_nettype wire

/* src/bclru_dp.sv */
// directory datapath: tags, counts, valid marks, recency ranks and result register
// depends on bclru_pkg and bclru_sel
`default_nettype none

module bclru_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bclru_pkg::t_cmd i_cmd,
    input  wire bclru_pkg::t_req i_req,
    output bclru_pkg::t_rsp      o_rsp
);

    bclru_pkg::t_req  r_req;
    bclru_pkg::t_rsp  r_rsp;
    logic [7:0]       r_tag_dev [bclru_pkg::NBUF];
    logic [31:0]      r_tag_sec [bclru_pkg::NBUF];
    logic [7:0]       r_count   [bclru_pkg::NBUF];
    bclru_pkg::t_rank r_rank    [bclru_pkg::NBUF];
    logic [bclru_pkg::NBUF-1:0] r_valid;

    logic [bclru_pkg::NBUF-1:0] w_match;
    logic [bclru_pkg::NBUF-1:0] w_free;
    bclru_pkg::t_rank w_key_hit  [bclru_pkg::NBUF];
    bclru_pkg::t_rank w_key_free [bclru_pkg::NBUF];
    logic             w_hit_found;
    bclru_pkg::t_slot w_hit_idx;
    logic             w_free_found;
    bclru_pkg::t_slot w_free_idx;

    // update decision for the commit cycle
    bclru_pkg::t_rsp  n_rsp;
    logic             w_wr;
    bclru_pkg::t_slot w_wr_slot;
    logic [7:0]       w_wr_count;
    logic             w_set_valid;
    logic             w_retag;
    logic             w_mru;
    bclru_pkg::t_slot w_s;
    logic [7:0]       w_cnt_s;
    logic [7:0]       w_cnt_hit;

    always_comb begin
        for (int i = 0; i < bclru_pkg::NBUF; i++) begin
            w_match[i]    = (r_tag_dev[i] == r_req.device) && (r_tag_sec[i] == r_req.sector);
            w_free[i]     = (r_count[i] == 8'd0);
            w_key_hit[i]  = r_rank[i];
            w_key_free[i] = ~r_rank[i];
        end
    end

    bclru_sel u_sel_hit (
        .i_clk   (i_clk),
        .i_mask  (w_match),
        .i_key   (w_key_hit),
        .o_found (w_hit_found),
        .o_idx   (w_hit_idx)
    );

    bclru_sel u_sel_free (
        .i_clk   (i_clk),
        .i_mask  (w_free),
        .i_key   (w_key_free),
        .o_found (w_free_found),
        .o_idx   (w_free_idx)
    );

    assign w_s       = r_req.slot_in;
    assign w_cnt_s   = r_count[w_s];
    assign w_cnt_hit = r_count[w_hit_idx];

    always_comb begin
        n_rsp       = '0;
        n_rsp.status = bclru_pkg::ST_OK;
        w_wr        = 1'b0;
        w_wr_slot   = w_s;
        w_wr_count  = '0;
        w_set_valid = 1'b0;
        w_retag     = 1'b0;
        w_mru       = 1'b0;
        if (r_req.action == bclru_pkg::ACT_ACQUIRE) begin
            if (w_hit_found) begin
                n_rsp.slot_out = 5'(w_hit_idx);
                n_rsp.hit      = 1'b1;
                w_wr_slot      = w_hit_idx;
                if (w_cnt_hit == bclru_pkg::COUNT_MAX) begin
                    n_rsp.count_after = bclru_pkg::COUNT_MAX;
                    n_rsp.status      = bclru_pkg::ST_OVER;
                end else begin
                    w_wr              = 1'b1;
                    w_wr_count        = w_cnt_hit + 8'd1;
                    w_set_valid       = 1'b1;
                    n_rsp.needs_read  = ~r_valid[w_hit_idx];
                    n_rsp.count_after = w_cnt_hit + 8'd1;
                end
            end else if (w_free_found) begin
                w_wr              = 1'b1;
                w_wr_slot         = w_free_idx;
                w_wr_count        = 8'd1;
                w_set_valid       = 1'b1;
                w_retag           = 1'b1;
                n_rsp.slot_out    = 5'(w_free_idx);
                n_rsp.needs_read  = 1'b1;
                n_rsp.count_after = 8'd1;
            end else begin
                n_rsp.status = bclru_pkg::ST_NOFREE;
            end
        end else begin
            n_rsp.slot_out = r_req.slot_in;
            if (32'(r_req.slot_in) >= bclru_pkg::NBUF) begin
                n_rsp.status = bclru_pkg::ST_NOFREE;
            end else if (r_req.action == bclru_pkg::ACT_PIN) begin
                if (w_cnt_s == bclru_pkg::COUNT_MAX) begin
                    n_rsp.count_after = bclru_pkg::COUNT_MAX;
                    n_rsp.status      = bclru_pkg::ST_OVER;
                end else begin
                    w_wr              = 1'b1;
                    w_wr_count        = w_cnt_s + 8'd1;
                    n_rsp.count_after = w_cnt_s + 8'd1;
                end
            end else begin
                if (w_cnt_s == 8'd0) begin
                    n_rsp.status = bclru_pkg::ST_UNDER;
                end else begin
                    w_wr              = 1'b1;
                    w_wr_count        = w_cnt_s - 8'd1;
                    n_rsp.count_after = w_cnt_s - 8'd1;
                    w_mru = (r_req.action == bclru_pkg::ACT_RELEASE) && (w_cnt_s == 8'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bclru_pkg::NBUF; i++) begin
                r_tag_dev[i] <= '1;
                r_tag_sec[i] <= '1;
                r_count[i]   <= '0;
                r_rank[i]    <= bclru_pkg::IDXW'(bclru_pkg::NBUF - 1 - i);
            end
            r_valid <= '0;
        end else if (i_cmd.commit) begin
            if (w_wr) begin
                r_count[w_wr_slot] <= w_wr_count;
            end
            if (w_set_valid) begin
                r_valid[w_wr_slot] <= 1'b1;
            end
            if (w_retag) begin
                r_tag_dev[w_wr_slot] <= r_req.device;
                r_tag_sec[w_wr_slot] <= r_req.sector;
            end
            if (w_mru) begin
                // slot moves to the front, more recent slots shift back by one
                for (int i = 0; i < bclru_pkg::NBUF; i++) begin
                    if (r_rank[i] < r_rank[w_s]) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
                r_rank[w_s] <= '0;
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

/* src/bclru_ctrl.sv */
// sequencing state machine and handshake control
// depends on bclru_pkg
`default_nettype none

module bclru_ctrl (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output bclru_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_PICK,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    assign o_cmd.load   = i_in_valid && r_in_ready;
    assign o_cmd.commit = (r_state == S_COMMIT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !o_cmd.commit) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_state    <= S_LOOK;
                        r_in_ready <= 1'b0;
                    end
                end
                S_LOOK: begin
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (o_cmd.commit) begin
                        r_state     <= S_IDLE;
                        r_in_ready  <= 1'b1;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_in_ready)
        else $error("input ready while an item is in flight");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_LOOK))
        else $error("accepted word did not start a lookup");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_out_valid && r_in_ready))
        else $error("commit did not present a result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.commit)
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

/* src/buffer_cache_lru_refcount.sv */
// top level of the buffer cache directory with reference counts and lru replacement
// depends on bclru_pkg, bclru_ctrl, bclru_dp (and bclru_sel below it)
//
//   channel   direction   handshake                  word
//   request   in          i_in_valid / o_in_ready    i_in_word  (t_req)
//   result    out         o_out_valid / i_out_ready  o_out_word (t_rsp)
//
// one result per request, formed after acceptance in steps: tag compare with group
// select, select across groups, commit
// a new request is taken the cycle after commit, never while one is still in flight
// commit waits while the previous result is still held in the output register
// synchronous active-low reset restores all tags, counts, valid marks and ranks at once
`default_nettype none

module buffer_cache_lru_refcount (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire bclru_pkg::t_req i_in_word,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output bclru_pkg::t_rsp      o_out_word
);

    bclru_pkg::t_cmd w_cmd;

    bclru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    bclru_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_in_word),
        .o_rsp   (o_out_word)
    );

endmodule

`default_nettype wire

/* dv/bclru_checker.sv */
// checker for the buffer cache directory: watches the request and result channels,
// keeps its own copy of tags, counts, valid marks and ranks, and compares every result word
// depends on bclru_pkg
module bclru_checker
    import bclru_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_req i_in_word,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_rsp i_out_word,
    output int   o_fail_count,
    output int   o_pending
);

    logic [7:0]  dir_device [NBUF];
    logic [31:0] dir_sector [NBUF];
    logic        dir_filled [NBUF];
    logic [7:0]  dir_refs   [NBUF];
    t_rank       dir_rank   [NBUF];
    t_rsp        rsp_due    [$];
    int          mismatch_cnt;

    task automatic serve_request(input t_req rq, output t_rsp rs);
        int    best;
        bit    found;
        int    s;
        t_rank old;
        rs    = '0;
        best  = 0;
        found = 1'b0;
        if (rq.action == ACT_ACQUIRE) begin
            // lowest rank wins among matching tags
            for (int i = 0; i < NBUF; i++) begin
                if (dir_device[i] == rq.device && dir_sector[i] == rq.sector &&
                    (!found || dir_rank[i] < dir_rank[best])) begin
                    best  = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                rs.slot_out = 5'(best);
                rs.hit      = 1'b1;
                if (dir_refs[best] == COUNT_MAX) begin
                    rs.count_after = COUNT_MAX;
                    rs.status      = ST_OVER;
                end else begin
                    dir_refs[best]   = dir_refs[best] + 8'd1;
                    rs.needs_read    = !dir_filled[best];
                    dir_filled[best] = 1'b1;
                    rs.count_after   = dir_refs[best];
                    rs.status        = ST_OK;
                end
            end else begin
                // victim is the least recent unreferenced slot
                for (int i = 0; i < NBUF; i++) begin
                    if (dir_refs[i] == 8'd0 && (!found || dir_rank[i] > dir_rank[best])) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    rs.status = ST_NOFREE;
                end else begin
                    dir_device[best] = rq.device;
                    dir_sector[best] = rq.sector;
                    dir_refs[best]   = 8'd1;
                    dir_filled[best] = 1'b1;
                    rs.slot_out      = 5'(best);
                    rs.needs_read    = 1'b1;
                    rs.count_after   = 8'd1;
                    rs.status        = ST_OK;
                end
            end
        end else begin
            s           = int'(rq.slot_in);
            rs.slot_out = rq.slot_in;
            if (s >= NBUF) begin
                rs.status = ST_NOFREE;
            end else if (rq.action == ACT_PIN) begin
                if (dir_refs[s] == COUNT_MAX) begin
                    rs.count_after = COUNT_MAX;
                    rs.status      = ST_OVER;
                end else begin
                    dir_refs[s]    = dir_refs[s] + 8'd1;
                    rs.count_after = dir_refs[s];
                end
            end else if (dir_refs[s] == 8'd0) begin
                rs.status = ST_UNDER;
            end else begin
                dir_refs[s] = dir_refs[s] - 8'd1;
                // a released slot that drops to zero becomes most recent
                if (rq.action == ACT_RELEASE && dir_refs[s] == 8'd0) begin
                    old = dir_rank[s];
                    for (int i = 0; i < NBUF; i++) begin
                        if (dir_rank[i] < old) begin
                            dir_rank[i] = dir_rank[i] + 1'b1;
                        end
                    end
                    dir_rank[s] = '0;
                end
                rs.count_after = dir_refs[s];
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rsp want;
        t_rsp fresh;
        if (!i_rst_n) begin
            for (int i = 0; i < NBUF; i++) begin
                dir_device[i] = '1;
                dir_sector[i] = '1;
                dir_filled[i] = 1'b0;
                dir_refs[i]   = '0;
                dir_rank[i]   = t_rank'(NBUF - 1 - i);
            end
            rsp_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (rsp_due.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("unexpected result word: slot %0d hit %0b rd %0b count %0d st %0d",
                                 i_out_word.slot_out, i_out_word.hit, i_out_word.needs_read,
                                 i_out_word.count_after, i_out_word.status);
                    end
                end else begin
                    want = rsp_due.pop_front();
                    if (i_out_word.slot_out !== want.slot_out || i_out_word.hit !== want.hit ||
                        i_out_word.needs_read !== want.needs_read ||
                        i_out_word.count_after !== want.count_after ||
                        i_out_word.status !== want.status) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("result mismatch: expected slot %0d hit %0b rd %0b count %0d st %0d",
                                     want.slot_out, want.hit, want.needs_read,
                                     want.count_after, want.status);
                            $display("                 got      slot %0d hit %0b rd %0b count %0d st %0d",
                                     i_out_word.slot_out, i_out_word.hit, i_out_word.needs_read,
                                     i_out_word.count_after, i_out_word.status);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                serve_request(i_in_word, fresh);
                rsp_due.push_back(fresh);
            end
        end
        o_pending    <= rsp_due.size();
        o_fail_count <= mismatch_cnt;
    end

endmodule

/* dv/tb_top.sv */
// top of the buffer cache directory testbench: clock, reset, request stimulus and result back-pressure
// depends on bclru_pkg, buffer_cache_lru_refcount and bclru_checker
module tb_top;
    import bclru_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_WORDS = 1200;
    localparam int STORM_LEN    = 258;

    typedef enum int {
        PH_FILL,
        PH_CHURN,
        PH_DRAIN
    } t_phase;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_req i_in_word   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_rsp o_out_word;

    int fail_count;
    int pending_count;
    int cycle_cnt    = 0;
    int ready_hold   = 0;
    bit sender_burst = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    buffer_cache_lru_refcount u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    bclru_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_word   (o_out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(0, 2);
        if (roll < 97) return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_req acquire_word(input logic [7:0] dv, input logic [31:0] sc);
        t_req w;
        w.action  = ACT_ACQUIRE;
        w.device  = dv;
        w.sector  = sc;
        w.slot_in = 5'($urandom);
        return w;
    endfunction

    function automatic t_req slot_word(input t_action act, input logic [4:0] s);
        t_req w;
        w.action  = act;
        w.device  = 8'($urandom);
        w.sector  = $urandom;
        w.slot_in = s;
        return w;
    endfunction

    function automatic t_req random_word(input t_phase ph);
        int          roll;
        int          acq_lim;
        int          rel_lim;
        int          pin_lim;
        logic [7:0]  dv;
        logic [31:0] sc;
        case (ph)
            PH_FILL: begin
                acq_lim = 75; rel_lim = 90; pin_lim = 95;
            end
            PH_CHURN: begin
                acq_lim = 45; rel_lim = 85; pin_lim = 90;
            end
            default: begin
                acq_lim = 15; rel_lim = 75; pin_lim = 80;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < acq_lim) begin
            // small tag pool so that hits and refills are common
            roll = $urandom_range(0, 99);
            if (roll < 85) begin
                dv = 8'($urandom_range(0, 3));
                sc = 32'($urandom_range(0, 15));
            end else if (roll < 95) begin
                dv = 8'($urandom);
                sc = $urandom;
            end else begin
                dv = '1;
                sc = '1;
            end
            return acquire_word(dv, sc);
        end
        if (roll < rel_lim) return slot_word(ACT_RELEASE, 5'($urandom_range(0, NBUF - 1)));
        if (roll < pin_lim) return slot_word(ACT_PIN, 5'($urandom_range(0, NBUF - 1)));
        return slot_word(ACT_UNPIN, 5'($urandom_range(0, NBUF - 1)));
    endfunction

    task automatic send_word(input t_req w);
        int gap;
        gap = sender_burst ? 0 : idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 1) == 1) begin
            i_out_ready <= 1'b1;
            ready_hold  <= ($urandom_range(0, 19) == 0) ? 200 : $urandom_range(0, 6);
        end else begin
            i_out_ready <= 1'b0;
            ready_hold  <= idle_len();
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int         sent;
        int         left;
        bit         storm_done;
        t_phase     ph;
        logic [4:0] storm_slot;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all-ones tag matches every slot after reset, none of them valid
        send_word(acquire_word(8'hFF, 32'hFFFF_FFFF));
        send_word(acquire_word(8'hFF, 32'hFFFF_FFFF));
        send_word(slot_word(ACT_RELEASE, 5'd31));
        send_word(slot_word(ACT_UNPIN, 5'd31));
        send_word(slot_word(ACT_UNPIN, 5'd31));
        send_word(slot_word(ACT_RELEASE, 5'd0));
        send_word(acquire_word(8'h00, 32'h0000_0000));
        send_word(acquire_word(8'hA5, 32'h5A5A_A5A5));
        send_word(acquire_word(8'h5A, 32'hA5A5_5A5A));
        send_word(slot_word(ACT_PIN, 5'd0));
        send_word(slot_word(ACT_PIN, 5'd31));
        send_word(slot_word(ACT_RELEASE, 5'd31));
        send_word(slot_word(ACT_RELEASE, 5'd31));
        send_word(acquire_word(8'h00, 32'h0000_0000));
        send_word(acquire_word(8'hFF, 32'h0000_0000));
        send_word(acquire_word(8'h00, 32'hFFFF_FFFF));
        send_word(slot_word(ACT_PIN, 5'd5));
        send_word(acquire_word(8'hFF, 32'hFFFF_FFFF));
        send_word(slot_word(ACT_UNPIN, 5'd5));
        send_word(slot_word(ACT_RELEASE, 5'd16));

        sent       = 0;
        storm_done = 1'b0;
        while (sent < RANDOM_WORDS) begin
            ph           = t_phase'($urandom_range(0, 2));
            sender_burst = ($urandom_range(0, 3) == 0);
            left         = $urandom_range(40, 120);
            if (!storm_done && sent >= 400) begin
                // drive one count past its ceiling and back through zero
                storm_slot = 5'($urandom_range(0, NBUF - 1));
                repeat (STORM_LEN) send_word(slot_word(ACT_PIN, storm_slot));
                repeat (STORM_LEN) send_word(slot_word(ACT_RELEASE, storm_slot));
                sent       += 2 * STORM_LEN;
                storm_done  = 1'b1;
            end
            repeat (left) send_word(random_word(ph));
            sent += left;
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* files.f */
src/bclru_pkg.sv
src/bclru_sel.sv
src/bclru_dp.sv
src/bclru_ctrl.sv
src/buffer_cache_lru_refcount.sv
dv/bclru_checker.sv
dv/tb_top.sv
